// File: design/vtx_pkg.sv
// ----------------------------------------------------------------------------
// vtx_pkg: shared types and constants for the 4x4 vertex transform
// Transaction structs for both channels, mode codes and fixed-point sizes.
// ----------------------------------------------------------------------------
package vtx_pkg;

   localparam int Q_FRAC     = 16;
   localparam int NUM_PAIRS  = 8;
   localparam int PAIR_IDX_W = $clog2(NUM_PAIRS);
   localparam int DIV_BITS   = 48;             // |num| * 2^16 fits in 48 bits
   localparam int DIV_LAT    = DIV_BITS + 1;   // operand stage plus one stage per bit

   localparam logic [1:0] CMD_HOMOG = 2'd0;
   localparam logic [1:0] CMD_POINT = 2'd1;
   localparam logic [1:0] CMD_DIR3  = 2'd2;
   localparam logic [1:0] CMD_DIR4  = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
      logic signed [31:0] in_w;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
      logic               divided;
   } rsp_type;

endpackage

// File: design/vertex_transform_4x4.sv
// ----------------------------------------------------------------------------
// vertex_transform_4x4: Q16.16 4x4 vertex transform with perspective divide
// Column-major matrix in csr registers, floor-scaled saturated dot products,
// pipelined divide of x, y and z by w in point mode.
// ----------------------------------------------------------------------------
//  channel  ports                          direction
//  req      req_valid req_stall req_data   in  (stall out)
//  rsp      rsp_valid rsp_stall rsp_data   out (stall in)
//  csr      csr_write csr_index csr_data   in
//
//  One transaction per cycle sustained while req_stall is low; stages from
//  acceptance to rsp_valid: multiply, two adder stages, 49 divider stages, output reg.
//  Reset loads the identity matrix and empties the pipeline.
//  A skid register behind the output lets the pipe keep moving while one result
//  waits; req_stall rises only when both output and skid are full.
// ----------------------------------------------------------------------------
module vertex_transform_4x4 (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  vtx_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output vtx_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_write,
   input  logic [vtx_pkg::PAIR_IDX_W-1:0]        csr_index,
   input  logic [63:0]                           csr_data
);
   import vtx_pkg::*;

   typedef struct packed {
      logic               do_div;
      logic signed [31:0] r0;
      logic signed [31:0] r1;
      logic signed [31:0] r2;
      logic signed [31:0] r3;
   } side_type;

   logic [63:0]        pair_ff [0:NUM_PAIRS-1];
   logic signed [31:0] mtx     [0:15];
   logic signed [31:0] vec     [0:3];

   logic               en;
   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [1:0]         s1_cmd_ff, s2_cmd_ff, s3_cmd_ff;
   logic signed [63:0] prod_ff [0:3][0:3];
   logic signed [64:0] half_ff [0:3][0:1];
   logic signed [31:0] row_ff  [0:3];
   logic signed [31:0] row_in  [0:3];
   logic signed [65:0] full_sum [0:3];
   logic signed [49:0] scaled  [0:3];

   side_type           side_ff [0:DIV_LAT-1];
   logic               side_valid_ff [0:DIV_LAT-1];
   logic signed [31:0] quot    [0:2];
   rsp_type            pipe_data;
   logic               pipe_valid;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               skid_valid_ff;
   rsp_type            skid_data_ff;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PAIRS; p++) begin
            if (p inside {0, 5})
               pair_ff[p] <= 64'd65536;
            else if (p inside {2, 7})
               pair_ff[p] <= 64'd65536 << 32;
            else
               pair_ff[p] <= '0;
         end
      end else if (csr_write) begin
         pair_ff[csr_index] <= csr_data;
      end
   end

   always_comb begin
      for (int e = 0; e < 16; e++)
         mtx[e] = e[0] ? signed'(pair_ff[e/2][63:32]) : signed'(pair_ff[e/2][31:0]);
      vec[0] = req_data.in_x;
      vec[1] = req_data.in_y;
      vec[2] = req_data.in_z;
      case (req_data.cmd)
         CMD_HOMOG: vec[3] = req_data.in_w;
         CMD_POINT: vec[3] = 32'sd65536;
         default:   vec[3] = 32'sd0;
      endcase
   end

   // stage 1: products, stage 2: pair sums, stage 3: floor scale and saturate
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         full_sum[k] = 66'(half_ff[k][0]) + 66'(half_ff[k][1]);
         scaled[k]   = 50'(full_sum[k] >>> Q_FRAC);
         if (!scaled[k][49] && (scaled[k][48:31] != '0))
            row_in[k] = 32'sh7FFF_FFFF;
         else if (scaled[k][49] && (scaled[k][48:31] != '1))
            row_in[k] = 32'sh8000_0000;
         else
            row_in[k] = scaled[k][31:0];
      end
      if (s2_cmd_ff == CMD_DIR3 || s2_cmd_ff == CMD_DIR4)
         row_in[3] = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_cmd_ff <= req_data.cmd;
         s2_cmd_ff <= s1_cmd_ff;
         s3_cmd_ff <= s2_cmd_ff;
         for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < 4; c++)
               prod_ff[k][c] <= 64'(mtx[c*4+k]) * 64'(vec[c]);
            half_ff[k][0] <= 65'(prod_ff[k][0]) + 65'(prod_ff[k][1]);
            half_ff[k][1] <= 65'(prod_ff[k][2]) + 65'(prod_ff[k][3]);
            row_ff[k]     <= row_in[k];
         end
      end
   end

   // divider lanes for x, y and z
   for (genvar g = 0; g < 3; g++) begin : g_div
      vtx_div u_div (
         .clock    (clock),
         .enable   (en),
         .num      (row_ff[g]),
         .den      (row_ff[3]),
         .quotient (quot[g])
      );
   end

   // side pipe carries undivided results alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) side_valid_ff[i] <= 1'b0;
      end else if (en) begin
         side_valid_ff[0] <= s3_valid_ff;
         for (int i = 1; i < DIV_LAT; i++) side_valid_ff[i] <= side_valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0].do_div <= (s3_cmd_ff == CMD_POINT) && (row_ff[3] != '0);
         side_ff[0].r0     <= row_ff[0];
         side_ff[0].r1     <= row_ff[1];
         side_ff[0].r2     <= row_ff[2];
         side_ff[0].r3     <= row_ff[3];
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i].do_div <= side_ff[i-1].do_div;
            side_ff[i].r0     <= side_ff[i-1].r0;
            side_ff[i].r1     <= side_ff[i-1].r1;
            side_ff[i].r2     <= side_ff[i-1].r2;
            side_ff[i].r3     <= side_ff[i-1].r3;
         end
      end
   end

   always_comb begin
      pipe_valid        = side_valid_ff[DIV_LAT-1];
      pipe_data.out_w   = side_ff[DIV_LAT-1].r3;
      pipe_data.divided = side_ff[DIV_LAT-1].do_div;
      if (side_ff[DIV_LAT-1].do_div) begin
         pipe_data.out_x = quot[0];
         pipe_data.out_y = quot[1];
         pipe_data.out_z = quot[2];
      end else begin
         pipe_data.out_x = side_ff[DIV_LAT-1].r0;
         pipe_data.out_y = side_ff[DIV_LAT-1].r1;
         pipe_data.out_z = side_ff[DIV_LAT-1].r2;
      end
   end

   // output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) begin
            rsp_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (pipe_valid) begin
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_data_ff  <= pipe_data;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= pipe_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

// File: design/vtx_div.sv
// ----------------------------------------------------------------------------
// vtx_div: pipelined Q16.16 divider lane
// Computes sat32(trunc(num * 2^16 / den)) with one quotient bit per stage.
// ----------------------------------------------------------------------------
module vtx_div (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic signed [31:0] quotient
);
   import vtx_pkg::*;

   logic [DIV_BITS-1:0] work_ff [0:DIV_BITS];
   logic [31:0]         rem_ff  [0:DIV_BITS];
   logic [31:0]         den_ff  [0:DIV_BITS];
   logic                neg_ff  [0:DIV_BITS];

   logic [DIV_BITS-1:0] work_in [0:DIV_BITS];
   logic [31:0]         rem_in  [0:DIV_BITS];

   logic [32:0]         num_abs;
   logic [32:0]         den_abs;
   logic [32:0]         trial   [0:DIV_BITS-1];
   logic [32:0]         diff    [0:DIV_BITS-1];
   logic [DIV_BITS-1:0] mag;

   always_comb begin
      num_abs = num[31] ? (33'd0 - {num[31], num}) : {1'b0, num};
      den_abs = den[31] ? (33'd0 - {den[31], den}) : {1'b0, den};
      work_in[0] = {num_abs[31:0], {Q_FRAC{1'b0}}};
      rem_in[0]  = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial[i] = {rem_ff[i], work_ff[i][DIV_BITS-1]};
         diff[i]  = trial[i] - {1'b0, den_ff[i]};
         if (!diff[i][32]) begin
            rem_in[i+1]  = diff[i][31:0];
            work_in[i+1] = {work_ff[i][DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in[i+1]  = trial[i][31:0];
            work_in[i+1] = {work_ff[i][DIV_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         work_ff[0] <= work_in[0];
         rem_ff[0]  <= rem_in[0];
         den_ff[0]  <= den_abs[31:0];
         neg_ff[0]  <= num[31] ^ den[31];
         for (int i = 1; i <= DIV_BITS; i++) begin
            work_ff[i] <= work_in[i];
            rem_ff[i]  <= rem_in[i];
            den_ff[i]  <= den_ff[i-1];
            neg_ff[i]  <= neg_ff[i-1];
         end
      end
   end

   // saturate the signed quotient to 32 bits
   always_comb begin
      mag = work_ff[DIV_BITS];
      if (neg_ff[DIV_BITS]) begin
         if ((mag[DIV_BITS-1:32] != '0) || (mag[31] && (mag[30:0] != '0)))
            quotient = 32'sh8000_0000;
         else
            quotient = 32'sd0 - signed'(mag[31:0]);
      end else begin
         if (mag[DIV_BITS-1:31] != '0)
            quotient = 32'sh7FFF_FFFF;
         else
            quotient = signed'(mag[31:0]);
      end
   end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression for the Q16.16 4x4 vertex transform
// Drives a directed table and then random vectors under several matrix
// settings. Results are checked against the table or a local fixed-point
// predictor, field by field and in order, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import vtx_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 70;

   typedef struct {
      int      mat;
      req_type item;
      bit      typed;
      rsp_type want;
   } vec_row_type;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 0;
   rsp_type               rsp_data;
   logic                  csr_write = 0;
   logic [PAIR_IDX_W-1:0] csr_index = '0;
   logic [63:0]           csr_data = '0;

   logic [63:0] matrix_pair [NUM_PAIRS];
   rsp_type     expected_vertices [$];
   vec_row_type directed [$];
   int          errors = 0;
   int          cycles = 0;
   bit          calm = 0;

   vertex_transform_4x4 dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("vertex_transform_4x4 regression: fail");
         $finish;
      end
   end

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic longint sat32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 64'sd2147483647;
      if (v < -128'sd2147483648) return -64'sd2147483648;
      return longint'(v);
   endfunction

   function automatic longint matrix_entry(int idx);
      logic [63:0] p;
      p = matrix_pair[idx >> 1];
      return (idx & 1) ? longint'($signed(p[63:32])) : longint'($signed(p[31:0]));
   endfunction

   function automatic rsp_type transform_vertex(req_type it);
      longint v [4];
      longint r [4];
      logic signed [127:0] acc;
      longint prod;
      rsp_type o;
      v[0] = it.in_x;
      v[1] = it.in_y;
      v[2] = it.in_z;
      case (it.cmd)
         CMD_HOMOG: v[3] = it.in_w;
         CMD_POINT: v[3] = 65536;
         default:   v[3] = 0;
      endcase
      for (int k = 0; k < 4; k++) begin
         acc = 0;
         for (int c = 0; c < 4; c++) begin
            prod = matrix_entry(c * 4 + k) * v[c];
            acc = acc + prod;
         end
         r[k] = sat32(acc >>> Q_FRAC);
      end
      if (it.cmd == CMD_DIR3 || it.cmd == CMD_DIR4) r[3] = 0;
      o.divided = 0;
      if (it.cmd == CMD_POINT && r[3] != 0) begin
         for (int k = 0; k < 3; k++) r[k] = sat32((r[k] * 65536) / r[3]);
         o.divided = 1;
      end
      o.out_x = r[0][31:0];
      o.out_y = r[1][31:0];
      o.out_z = r[2][31:0];
      o.out_w = r[3][31:0];
      return o;
   endfunction

   function automatic logic [31:0] rand_entry(int kind);
      case (kind)
         4: return $urandom;
         6: return 32'h7fff_ffff;
         7: return 32'h8000_0000;
         default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      endcase
   endfunction

   // 0 identity, 1 zero w row, 2 tiny w from x, 3 identity with large scale,
   // 4 random full range, 5 random small, 6 all max, 7 all min, 8 sparse w row
   task automatic load_matrix(int kind);
      logic [31:0] e [16];
      for (int i = 0; i < 16; i++) e[i] = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
      case (kind)
         1: e[15] = 0;
         2: begin
            e[15] = 0;
            e[3] = 32'd1;
         end
         3: for (int i = 0; i < 16; i++) e[i] = (i % 5 == 0) ? 32'h7fff_ffff : 32'h0;
         4, 5, 6, 7: for (int i = 0; i < 16; i++) e[i] = rand_entry(kind);
         8: begin
            for (int i = 0; i < 16; i++) e[i] = rand_entry(5);
            for (int i = 3; i < 16; i += 4)
               if ($urandom_range(0, 2) != 0) e[i] = 0;
         end
         default: ;
      endcase
      // drain before touching the matrix
      req_valid <= 0;
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      for (int i = 0; i < NUM_PAIRS; i++) begin
         csr_write <= 1;
         csr_index <= PAIR_IDX_W'(i);
         csr_data <= {e[2 * i + 1], e[2 * i]};
         matrix_pair[i] = {e[2 * i + 1], e[2 * i]};
         @(posedge clock);
      end
      csr_write <= 0;
   endtask

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_vertex(req_type it, bit typed, rsp_type want);
      int gap;
      req_valid <= 1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      expected_vertices.push_back(typed ? want : transform_vertex(it));
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 7))
         0, 1:    return $urandom;
         2:       return 32'h7fff_ffff;
         3:       return 32'h8000_0000;
         default: return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
      endcase
   endfunction

   function automatic vec_row_type mk(int m, logic [1:0] c, int x, int y, int z, int w,
                                      bit typed = 0, int ex = 0, int ey = 0, int ez = 0,
                                      int ew = 0, bit d = 0);
      vec_row_type r;
      r.mat = m;
      r.item = '{cmd: c, in_x: x, in_y: y, in_z: z, in_w: w};
      r.typed = typed;
      r.want = '{out_x: ex, out_y: ey, out_z: ez, out_w: ew, divided: d};
      return r;
   endfunction

   // receiver stall: runs of random length, none begins while calm
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (calm) begin
         rsp_stall <= 0;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                    : $urandom_range(0, 3);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_vertices.size() == 0) begin
            report("unexpected transaction", 0, 0);
         end else begin
            want = expected_vertices.pop_front();
            if (rsp_data.out_x !== want.out_x) report("out_x", rsp_data.out_x, want.out_x);
            if (rsp_data.out_y !== want.out_y) report("out_y", rsp_data.out_y, want.out_y);
            if (rsp_data.out_z !== want.out_z) report("out_z", rsp_data.out_z, want.out_z);
            if (rsp_data.out_w !== want.out_w) report("out_w", rsp_data.out_w, want.out_w);
            if (rsp_data.divided !== want.divided)
               report("divided", rsp_data.divided, want.divided);
         end
      end
   end

   initial begin
      int cur_mat;
      int kinds [9];
      req_type it;
      rsp_type none;
      kinds = '{4, 5, 6, 7, 5, 8, 4, 0, 5};
      none = '0;
      matrix_pair = '{64'd65536, 64'd0, 64'd281474976710656, 64'd0,
                      64'd0, 64'd65536, 64'd0, 64'd281474976710656};
      // identity after reset: results readable directly
      directed.push_back(mk(0, CMD_HOMOG, 65536, -131072, 3, 7, 1, 65536, -131072, 3, 7, 0));
      directed.push_back(mk(0, CMD_HOMOG, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h7fffffff, 1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h7fffffff, 0));
      directed.push_back(mk(0, CMD_HOMOG, 32'h80000000, 32'h80000000, 32'h80000000,
                            32'h80000000, 1, 32'h80000000, 32'h80000000, 32'h80000000,
                            32'h80000000, 0));
      directed.push_back(mk(0, CMD_POINT, 5, -9, 32'h7fffffff, 123, 1,
                            5, -9, 32'h7fffffff, 65536, 1));
      directed.push_back(mk(0, CMD_POINT, 32'h80000000, 0, -1, -55, 1,
                            32'h80000000, 0, -1, 65536, 1));
      directed.push_back(mk(0, CMD_DIR3, 100, 200, -300, 999, 1, 100, 200, -300, 0, 0));
      directed.push_back(mk(0, CMD_DIR4, -1, 32'h7fffffff, 32'h80000000, 42, 1,
                            -1, 32'h7fffffff, 32'h80000000, 0, 0));
      // w row all zero: point mode passes through undivided
      directed.push_back(mk(1, CMD_POINT, 65536, -65536, 77, 5, 1, 65536, -65536, 77, 0, 0));
      directed.push_back(mk(1, CMD_POINT, 32'h7fffffff, 32'h80000000, 0, 0, 1,
                            32'h7fffffff, 32'h80000000, 0, 0, 0));
      directed.push_back(mk(1, CMD_HOMOG, 10, 20, 30, 40));
      // tiny w: floor turns a small negative sum into -1 and the divide happens
      directed.push_back(mk(2, CMD_POINT, -1, 3, 4, 0));
      directed.push_back(mk(2, CMD_POINT, 1, 3, 4, 0));
      directed.push_back(mk(2, CMD_POINT, 32'h80000000, 32'h7fffffff, -7, 0));
      directed.push_back(mk(2, CMD_POINT, 32'h7fffffff, 32'h80000000, 9, 0));
      // saturation through large diagonal
      directed.push_back(mk(3, CMD_HOMOG, 32'h7fffffff, 32'h80000000, 65536, -65536));
      directed.push_back(mk(3, CMD_POINT, 3, -2, 65536, 0));
      directed.push_back(mk(3, CMD_DIR3, 32'h80000000, 1, -1, 0));
      directed.push_back(mk(3, CMD_DIR4, 131072, 32'h7fffffff, 0, 0));
      repeat (4) @(posedge clock);
      reset <= 0;
      cur_mat = 0;
      foreach (directed[i]) begin
         if (directed[i].mat != cur_mat) begin
            cur_mat = directed[i].mat;
            load_matrix(cur_mat);
         end
         send_vertex(directed[i].item, directed[i].typed, directed[i].want);
      end
      foreach (kinds[p]) begin
         load_matrix(kinds[p]);
         calm = (p % 4 == 3);
         for (int n = 0; n < 200; n++) begin
            it.cmd = 2'($urandom_range(0, 3));
            it.in_x = rand_comp();
            it.in_y = rand_comp();
            it.in_z = rand_comp();
            it.in_w = rand_comp();
            send_vertex(it, 0, none);
         end
      end
      req_valid <= 0;
      calm = 0;
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("vertex_transform_4x4 regression: pass");
      end else begin
         $display("vertex_transform_4x4 regression: fail");
      end
      $finish;
   end
endmodule

// File: sim.f
design/vtx_pkg.sv
design/vtx_div.sv
design/vertex_transform_4x4.sv
tb/tb_top.sv
